@@ hdl/eacc_pkg.sv @@
// Shared widths, register indexes, reset values and coding constants for the encoder CC block.
package eacc_pkg;

	localparam int ENC_IDX_W  = 3;
	localparam int DELTA_W    = 16;
	localparam int TIME_W     = 32;
	localparam int CTRL_W     = 7;
	localparam int CC_W       = 7;
	localparam int DEB_W      = 8;
	localparam int WIN_W      = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int PROD_W     = DELTA_W + WIN_W;
	localparam int SAT_W      = 6;

	localparam int ENC_COUNT_DEF = 8;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_CONTROL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL_WINDOW  = 2'd2;

	localparam logic [CTRL_W-1:0] FIRST_CONTROL_RST = 7'd16;
	localparam logic [DEB_W-1:0]  DEBOUNCE_RST      = 8'd2;
	localparam logic [WIN_W-1:0]  ACCEL_WINDOW_RST  = 10'd100;

	localparam logic [SAT_W-1:0] SAT_LIMIT = 6'd63;
	localparam logic [CC_W-1:0]  NEG_BASE  = 7'd64;

endpackage

@@ hdl/eacc_if.sv @@
// Valid/ready channel interfaces for encoder reports, CC results and register writes.
interface eacc_report_if;
	logic                                valid;
	logic                                ready;
	logic [eacc_pkg::ENC_IDX_W-1:0]      encoder_index;
	logic signed [eacc_pkg::DELTA_W-1:0] rotation_delta;
	logic [eacc_pkg::TIME_W-1:0]         now_ms;

	modport source (output valid, encoder_index, rotation_delta, now_ms, input ready);
	modport sink (input valid, encoder_index, rotation_delta, now_ms, output ready);
endinterface

interface eacc_cc_if;
	logic                          valid;
	logic                          ready;
	logic [eacc_pkg::CTRL_W-1:0]   control_number;
	logic [eacc_pkg::CC_W-1:0]     cc_value;

	modport source (output valid, control_number, cc_value, input ready);
	modport sink (input valid, control_number, cc_value, output ready);
endinterface

interface eacc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [eacc_pkg::CFG_IDX_W-1:0]  index;
	logic [eacc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/eacc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module eacc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ hdl/eacc_div.sv @@
// Restoring divider, one quotient bit per cycle, for window over elapsed time.
module eacc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [eacc_pkg::WIN_W-1:0] dividend,
	input  logic [eacc_pkg::WIN_W-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [eacc_pkg::WIN_W-1:0] quotient
);
	import eacc_pkg::*;

	localparam int CW = $clog2(WIN_W);

	logic [WIN_W-1:0] rem_q;
	logic [WIN_W-1:0] quo_q;
	logic [WIN_W-1:0] dsr_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [WIN_W:0]   rem_shift;
	logic [WIN_W+1:0] diff;
	logic             neg;

	// shift in next dividend bit, trial subtract
	assign rem_shift = {rem_q, quo_q[WIN_W-1]};
	assign diff      = {1'b0, rem_shift} - {2'b00, dsr_q};
	assign neg       = diff[WIN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				dsr_q  <= divisor;
			end else if (busy_q) begin
				rem_q <= neg ? rem_shift[WIN_W-1:0] : diff[WIN_W-1:0];
				quo_q <= {quo_q[WIN_W-2:0], ~neg};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;
endmodule

@@ hdl/encoder_accel_relative_cc.sv @@
// An unaccelerated report passes S_TIME, S_MUL and S_OUT before its CC item shows; one
// that goes through the divider also waits in S_DIV until the divider is done. Reports
// are taken only in S_IDLE, so the serial divider holds off the next one; debounced
// reports go back to idle from S_TIME, zero counts and out-of-range indexes stay idle.
// An untaken CC item holds the next item in S_OUT, and so the report channel, until taken.
// Reset (arst_n low, async): registers 16 / 2 / 100, timestamps read zero, nothing pending.
module encoder_accel_relative_cc #(
	parameter int ENC_COUNT = eacc_pkg::ENC_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	eacc_report_if.sink report,
	eacc_cc_if.source   cc,
	eacc_cfg_if.sink    cfg
);
	import eacc_pkg::*;

	localparam int AW = (ENC_COUNT > 1) ? $clog2(ENC_COUNT) : 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TIME,
		S_DIV,
		S_MUL,
		S_OUT
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CTRL_W-1:0] first_control_q;
	logic [DEB_W-1:0]  debounce_q;
	logic [WIN_W-1:0]  window_q;

	// item context
	logic [ENC_IDX_W-1:0] idx_q;
	logic [AW-1:0]        addr_q;
	logic                 neg_q;
	logic [DELTA_W-1:0]   mag_q;
	logic [TIME_W-1:0]    now_q;
	logic                 accel_q;
	logic [PROD_W-1:0]    prod_q;

	// result register
	logic              cc_valid_q;
	logic [CTRL_W-1:0] cc_ctrl_q;
	logic [CC_W-1:0]   cc_value_q;
	logic              cc_load;

	// timestamp store: RAM plus valid bits so unwritten entries read as zero
	logic [ENC_COUNT-1:0] tvalid_q;
	logic [TIME_W-1:0]    ram_rdata;
	logic                 ram_we;

	logic                report_acc;
	logic                in_range;
	logic [TIME_W-1:0]   old_time;
	logic [TIME_W-1:0]   elapsed;
	logic                debounced;
	logic                accel;
	logic                div_start;
	logic                div_busy;
	logic                div_done;
	logic [WIN_W-1:0]    div_quo;
	logic [WIN_W-1:0]    factor;
	logic [SAT_W-1:0]    sat_mag;
	logic [CC_W-1:0]     value;

	assign report.ready = (state_q == S_IDLE);
	assign report_acc   = report.valid && report.ready;
	assign in_range     = 32'(report.encoder_index) < ENC_COUNT;

	// elapsed time, modulo 2^32; only valid in S_TIME when RAM data has arrived
	assign old_time  = tvalid_q[addr_q] ? ram_rdata : '0;
	assign elapsed   = now_q - old_time;
	assign debounced = elapsed <= TIME_W'(debounce_q);
	assign accel     = elapsed < TIME_W'(window_q);
	assign ram_we    = (state_q == S_TIME);
	assign div_start = (state_q == S_TIME) && !debounced && accel;

	eacc_ram #(
		.WIDTH (TIME_W),
		.DEPTH (ENC_COUNT),
		.AW    (AW)
	) u_time_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (addr_q),
		.wdata (now_q),
		.re    (report_acc),
		.raddr (AW'(report.encoder_index)),
		.rdata (ram_rdata)
	);

	// elapsed is below the window here, so its low bits are the whole value
	eacc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (window_q),
		.divisor  (elapsed[WIN_W-1:0]),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign factor  = accel_q ? div_quo : WIN_W'(1);
	// saturate the magnitude, then code sign as 64 plus magnitude
	assign sat_mag = (prod_q > PROD_W'(SAT_LIMIT)) ? SAT_LIMIT : prod_q[SAT_W-1:0];
	assign value   = neg_q ? (NEG_BASE + CC_W'(sat_mag)) : CC_W'(sat_mag);

	// load the result register once it is empty or being drained this cycle
	assign cc_load = (state_q == S_OUT) && (!cc_valid_q || cc.ready);

	// configuration writes; indexes beyond the list are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_control_q <= FIRST_CONTROL_RST;
			debounce_q      <= DEBOUNCE_RST;
			window_q        <= ACCEL_WINDOW_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_FIRST_CONTROL: first_control_q <= cfg.data[CTRL_W-1:0];
				REG_DEBOUNCE_MS:   debounce_q      <= cfg.data[DEB_W-1:0];
				REG_ACCEL_WINDOW:  window_q        <= cfg.data[WIN_W-1:0];
				default:           ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_q <= '0;
		end else if (ram_we) begin
			tvalid_q[addr_q] <= 1'b1;
		end
	end

	// sequencer: state, item context and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cc_valid_q <= 1'b0;
		end else begin
			if (cc_load) begin
				cc_valid_q <= 1'b1;
			end else if (cc_valid_q && cc.ready) begin
				cc_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					// drop zero counts and unknown encoders without touching state
					if (report_acc && report.rotation_delta != '0 && in_range) begin
						idx_q   <= report.encoder_index;
						addr_q  <= AW'(report.encoder_index);
						neg_q   <= report.rotation_delta[DELTA_W-1];
						mag_q   <= report.rotation_delta[DELTA_W-1] ?
						           DELTA_W'(-report.rotation_delta) :
						           DELTA_W'(report.rotation_delta);
						now_q   <= report.now_ms;
						state_q <= S_TIME;
					end
				end
				S_TIME: begin
					// timestamp is written this cycle whatever the outcome
					accel_q <= accel;
					if (debounced) begin
						state_q <= S_IDLE;
					end else if (accel) begin
						state_q <= S_DIV;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_DIV: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= PROD_W'(mag_q) * PROD_W'(factor);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// hold until the result register is free
					if (cc_load) begin
						cc_ctrl_q  <= first_control_q + CTRL_W'(idx_q);
						cc_value_q <= value;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cc.valid          = cc_valid_q;
	assign cc.control_number = cc_ctrl_q;
	assign cc.cc_value       = cc_value_q;

	// a new report is never taken while the divider still works on the last one
	a_ready_not_div: assert property (@(posedge clk) disable iff (!arst_n)
		report.ready |-> !div_busy)
		else $error("report accepted while divider busy");

	// the divider finishes only while the sequencer waits for it
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide state");

	// a zero count leaves the sequencer idle
	a_zero_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		(report_acc && report.rotation_delta == '0) |=> state_q == S_IDLE)
		else $error("zero count started processing");

	// a nonzero count never codes as zero or bare negative base
	a_value_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cc.valid |-> (cc.cc_value != '0 && cc.cc_value != NEG_BASE))
		else $error("illegal relative CC value");

endmodule
